// ===== sv/r2c_pkg.sv =====
package r2c_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_COEF    = 2'd0,
        REQ_PIXEL   = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_NONE    = 2'd3
    } r2c_req_t;

    // configuration register indexes
    localparam logic [1:0] CFG_KERNEL_DIM   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // field widths fixed by the stream format
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = CH_W + 1 + COEF_W;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    // one tap handed from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic                     vld;
        logic                     last;
        logic [PIX_W-1:0]         px;
        logic signed [COEF_W-1:0] coef;
    } r2c_tap_t;

endpackage

// ===== sv/r2c_mac.sv =====
module r2c_mac import r2c_pkg::*; #(
    parameter int COEF_FRAC_BITS = 12,
    parameter int ACC_W          = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  r2c_tap_t         tap,
    output logic             done,
    output logic [PIX_W-1:0] rgb
);

    localparam logic [ACC_W:0] RND = (ACC_W+1)'(1) << (COEF_FRAC_BITS - 1);

    logic                     s2_vld_reg;
    logic                     s2_last_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic signed [PROD_W-1:0] prod_g_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [ACC_W-1:0]  acc_r_reg;
    logic signed [ACC_W-1:0]  acc_g_reg;
    logic signed [ACC_W-1:0]  acc_b_reg;
    logic                     done_reg;

    // round half up, then clamp to a byte
    function automatic logic [CH_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W:0] biased;
        logic [ACC_W:0] sh;
        biased = {acc[ACC_W-1], acc} + RND;
        sh     = biased >> COEF_FRAC_BITS;
        if (biased[ACC_W]) begin
            return '0;
        end else if (sh > (ACC_W+1)'(255)) begin
            return '1;
        end
        return sh[CH_W-1:0];
    endfunction

    // multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg  <= 1'b0;
            s2_last_reg <= 1'b0;
        end else begin
            s2_vld_reg  <= tap.vld;
            s2_last_reg <= tap.vld & tap.last;
        end
        prod_r_reg <= $signed({1'b0, tap.px[3*CH_W-1:2*CH_W]}) * tap.coef;
        prod_g_reg <= $signed({1'b0, tap.px[2*CH_W-1:CH_W]}) * tap.coef;
        prod_b_reg <= $signed({1'b0, tap.px[CH_W-1:0]}) * tap.coef;
    end

    // accumulate stage; clear when a new output pixel starts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= s2_vld_reg & s2_last_reg;
        end
        if (clr) begin
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end else if (s2_vld_reg) begin
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
            acc_g_reg <= acc_g_reg + ACC_W'(prod_g_reg);
            acc_b_reg <= acc_b_reg + ACC_W'(prod_b_reg);
        end
    end

    assign done = done_reg;
    assign rgb  = {round_sat(acc_r_reg), round_sat(acc_g_reg), round_sat(acc_b_reg)};

endmodule

// ===== sv/rgb_2d_convolution.sv =====
// Square 2D convolution of an RGB image held in an on-chip frame store.
// Input stream (s_*): s_tuser selects the request. A coefficient load writes
// one kernel tap, a pixel load writes one frame entry, a compute request
// names an output pixel. Result stream (m_*):
// one transaction per compute request that lies inside the image, carrying
// the pixel position and the three filtered channels.
// Configuration: cfg_we writes cfg_data to register cfg_index (kernel_dim,
// image_width, image_height); write only while idle.
// Busy period: a compute request holds s_tready low through one frame store
// read for the center pixel, then one multiply-accumulate per kernel tap,
// each with a frame store read when the tap lies inside the image, then the
// multiply/accumulate pipeline drains and the result is registered. An
// empty kernel skips straight to the result register.
// A request outside the image is dropped in its accept cycle.
// The result sits in an output register; loads are still taken while it
// waits on m_tready, a further compute finishes and then holds until the
// register frees up. Reset clears the handshake state and restores the
// configuration defaults; the frame and kernel stores keep their contents
// and must be written before use.
module rgb_2d_convolution import r2c_pkg::*; #(
    parameter int MAX_DIM        = 7,
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: coeff_index[6], coeff_value[16], pixel_row[8],
    // pixel_col[8], in_red[8], in_green[8], in_blue[8], zero pad[2]
    input  logic [S_DATA_W-1:0]   s_tdata,
    // s_tuser: req_type[2]
    input  logic [1:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: out_row[8], out_col[8], out_red[8], out_green[8],
    // out_blue[8]
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int KDEPTH = MAX_DIM * MAX_DIM;
    localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = CH_W + 1 + DIM_W;
    localparam int ACC_W  = PROD_W + $clog2(KDEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CTR,
        S_TAP,
        S_DRAIN,
        S_OUT
    } state_t;

    // configuration registers
    logic [2:0]            kernel_dim_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    // request fields
    r2c_req_t              req;
    logic [5:0]            coeff_index;
    logic [COEF_W-1:0]     coeff_value;
    logic [CH_W-1:0]       pixel_row;
    logic [CH_W-1:0]       pixel_col;
    logic [PIX_W-1:0]      in_pix;
    logic                  s_acc;

    // effective sizes
    logic [DIM_W-1:0]      dim_eff;
    logic [CFG_DATA_W-1:0] w_eff;
    logic [CFG_DATA_W-1:0] h_eff;
    logic                  in_img;

    // sequencer
    state_t                state_reg;
    logic [CH_W-1:0]       row_reg;
    logic [CH_W-1:0]       col_reg;
    logic [DIM_W-1:0]      dim_reg;
    logic [DIM_W-1:0]      half_reg;
    logic [CFG_DATA_W-1:0] w_reg;
    logic [CFG_DATA_W-1:0] h_reg;
    logic [DIM_W-1:0]      kr_reg;
    logic [DIM_W-1:0]      kc_reg;
    logic [KA_W-1:0]       kidx_reg;
    logic                  ctr_cap_reg;
    logic [PIX_W-1:0]      center_reg;
    logic                  s1_vld_reg;
    logic                  s1_last_reg;
    logic                  s1_inb_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    // tap position
    logic signed [POS_W-1:0] pr;
    logic signed [POS_W-1:0] pc;
    logic                    tap_inb;
    logic                    tap_last;
    logic [FA_W-1:0]         tap_addr;
    logic [FA_W-1:0]         ctr_addr;

    // memories
    logic [PIX_W-1:0]         frame_mem [FDEPTH];
    logic [PIX_W-1:0]         frame_q;
    logic                     fs_we;
    logic [FA_W-1:0]          fs_waddr;
    logic                     fs_re;
    logic [FA_W-1:0]          fs_raddr;
    logic signed [COEF_W-1:0] kern_mem [KDEPTH];
    logic signed [COEF_W-1:0] kern_q;
    logic                     ks_we;

    // accumulator interface
    r2c_tap_t              tap;
    logic                  mac_clr;
    logic                  mac_done;
    logic [PIX_W-1:0]      mac_rgb;

    assign req         = r2c_req_t'(s_tuser);
    assign coeff_index = s_tdata[5:0];
    assign coeff_value = s_tdata[21:6];
    assign pixel_row   = s_tdata[29:22];
    assign pixel_col   = s_tdata[37:30];
    assign in_pix      = {s_tdata[45:38], s_tdata[53:46], s_tdata[61:54]};

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_dim_reg   <= 3'd3;
            image_width_reg  <= CFG_DATA_W'(256);
            image_height_reg <= CFG_DATA_W'(256);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KERNEL_DIM:   kernel_dim_reg   <= cfg_data[2:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp configuration into the supported range
    always_comb begin
        dim_eff = (int'(kernel_dim_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(kernel_dim_reg);
        if (image_width_reg == '0) begin
            w_eff = CFG_DATA_W'(1);
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            w_eff = CFG_DATA_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_eff = CFG_DATA_W'(1);
        end else if (int'(image_height_reg) > MAX_HEIGHT) begin
            h_eff = CFG_DATA_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
        in_img = ({1'b0, pixel_row} < h_eff) && ({1'b0, pixel_col} < w_eff);
    end

    // neighbor position of the current tap
    always_comb begin
        pr       = POS_W'(row_reg) - POS_W'(half_reg) + POS_W'(kr_reg);
        pc       = POS_W'(col_reg) - POS_W'(half_reg) + POS_W'(kc_reg);
        tap_inb  = !pr[POS_W-1] && !pc[POS_W-1] &&
                   (pr < POS_W'(h_reg)) && (pc < POS_W'(w_reg));
        tap_last = (kr_reg == dim_reg - DIM_W'(1)) && (kc_reg == dim_reg - DIM_W'(1));
        tap_addr = FA_W'(pr[CH_W-1:0]) * FA_W'(MAX_WIDTH) + FA_W'(pc[CH_W-1:0]);
        ctr_addr = FA_W'(row_reg) * FA_W'(MAX_WIDTH) + FA_W'(col_reg);
    end

    // memory port control
    always_comb begin
        fs_we    = s_acc && (req == REQ_PIXEL) &&
                   (int'(pixel_row) < MAX_HEIGHT) && (int'(pixel_col) < MAX_WIDTH);
        fs_waddr = FA_W'(pixel_row) * FA_W'(MAX_WIDTH) + FA_W'(pixel_col);
        fs_re    = (state_reg == S_CTR) || ((state_reg == S_TAP) && tap_inb);
        fs_raddr = (state_reg == S_CTR) ? ctr_addr : tap_addr;
        ks_we    = s_acc && (req == REQ_COEF) && (int'(coeff_index) < KDEPTH);
        mac_clr  = s_acc && (req == REQ_COMPUTE) && in_img;
    end

    // frame store
    always_ff @(posedge aclk) begin
        if (fs_we) begin
            frame_mem[fs_waddr] <= in_pix;
        end
        if (fs_re) begin
            frame_q <= frame_mem[fs_raddr];
        end
    end

    // kernel store
    always_ff @(posedge aclk) begin
        if (ks_we) begin
            kern_mem[KA_W'(coeff_index)] <= $signed(coeff_value);
        end
        if (state_reg == S_TAP) begin
            kern_q <= kern_mem[kidx_reg];
        end
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ctr_cap_reg  <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= (state_reg == S_TAP);
            s1_last_reg <= (state_reg == S_TAP) && tap_last;
            s1_inb_reg  <= tap_inb;
            ctr_cap_reg <= (state_reg == S_CTR);
            if (ctr_cap_reg) begin
                center_reg <= frame_q;
            end
            // drop a taken result unless a new one replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc && (req == REQ_COMPUTE) && in_img) begin
                        row_reg  <= pixel_row;
                        col_reg  <= pixel_col;
                        dim_reg  <= dim_eff;
                        half_reg <= dim_eff >> 1;
                        w_reg    <= w_eff;
                        h_reg    <= h_eff;
                        kr_reg   <= '0;
                        kc_reg   <= '0;
                        kidx_reg <= '0;
                        state_reg <= (dim_eff == '0) ? S_OUT : S_CTR;
                    end
                end
                S_CTR: begin
                    state_reg <= S_TAP;
                end
                S_TAP: begin
                    // advance row-major through the kernel
                    kidx_reg <= kidx_reg + KA_W'(1);
                    if (kc_reg == dim_reg - DIM_W'(1)) begin
                        kc_reg <= '0;
                        kr_reg <= kr_reg + DIM_W'(1);
                    end else begin
                        kc_reg <= kc_reg + DIM_W'(1);
                    end
                    if (tap_last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (mac_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {mac_rgb[CH_W-1:0], mac_rgb[2*CH_W-1:CH_W],
                                         mac_rgb[3*CH_W-1:2*CH_W], col_reg, row_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // pick the neighbor or, off the image, the center pixel
    always_comb begin
        tap.vld  = s1_vld_reg;
        tap.last = s1_last_reg;
        tap.px   = s1_inb_reg ? frame_q : center_reg;
        tap.coef = kern_q;
    end

    r2c_mac #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .ACC_W         (ACC_W)
    ) u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clr    (mac_clr),
        .tap    (tap),
        .done   (mac_done),
        .rgb    (mac_rgb)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/r2c_chk.sv =====
module r2c_chk import r2c_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [1:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the block only goes busy on a compute transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tuser == REQ_COMPUTE))
        else $error("busy without a compute transaction");

    // a new result is produced only while busy
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind rgb_2d_convolution r2c_chk u_r2c_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
